/* rtl/core/knsp_pkg.sv */
// ----------------------------------------------------------------------------
// knsp_pkg
// Shared types and constants for the knight weighted shortest path unit.
// ----------------------------------------------------------------------------
`default_nettype none

package knsp_pkg;

  // Board side used when the top level is not told otherwise.
  localparam int BOARD_SIDE_DEF = 8;

  // Width of the row and column fields of a query.
  localparam int COORD_IN_W = 3;

  // Distance encoding: all ones means not reached yet.
  localparam int DIST_W = 13;
  localparam logic [DIST_W-1:0] DIST_INF        = 13'd8191;
  localparam logic [DIST_W-1:0] DIST_MAX_FINITE = 13'd8190;

  // The eight knight moves, as row and column offsets.
  localparam int MOVE_CNT = 8;
  localparam int MOVE_W   = 3;
  localparam logic signed [2:0] MOVE_DR [MOVE_CNT] = '{
    -3'sd1, -3'sd2, -3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd1
  };
  localparam logic signed [2:0] MOVE_DC [MOVE_CNT] = '{
    -3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2
  };

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BASE,
    ST_MREAD,
    ST_MWRITE,
    ST_FINISH,
    ST_REPORT
  } knsp_state_t;

endpackage

`default_nettype wire

/* rtl/core/knsp_dist_mem.sv */
// ----------------------------------------------------------------------------
// knsp_dist_mem
// Square distance memory: one write and one registered read per cycle.
// A per-entry valid bit makes an unwritten entry read as infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module knsp_dist_mem #(
  parameter int DEPTH = knsp_pkg::BOARD_SIDE_DEF * knsp_pkg::BOARD_SIDE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          clear,
  input  wire                          we,
  input  wire [AW-1:0]                 waddr,
  input  wire [knsp_pkg::DIST_W-1:0]   wdata,
  input  wire                          re,
  input  wire [AW-1:0]                 raddr,
  output logic [knsp_pkg::DIST_W-1:0]  rdata
);

  logic [knsp_pkg::DIST_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write in the clearing cycle still marks its own entry valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (clear) begin
        valid <= '0;
      end
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : knsp_pkg::DIST_INF;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/knsp_move_calc.sv */
// ----------------------------------------------------------------------------
// knsp_move_calc
// Neighbor square, board check and saturated candidate cost of one move.
// ----------------------------------------------------------------------------
`default_nettype none

module knsp_move_calc #(
  parameter int BOARD_SIDE = knsp_pkg::BOARD_SIDE_DEF,
  parameter int RW         = $clog2(BOARD_SIDE),
  parameter int AW         = $clog2(BOARD_SIDE * BOARD_SIDE)
) (
  input  wire [RW-1:0]                    row,
  input  wire [RW-1:0]                    col,
  input  wire [knsp_pkg::MOVE_W-1:0]      move,
  input  wire [knsp_pkg::DIST_W-1:0]      base,
  output logic                            on_board,
  output logic [AW-1:0]                   nidx,
  output logic [knsp_pkg::DIST_W-1:0]     cand
);

  localparam int SW = RW + 2;
  localparam int PW = 2 * RW;

  logic signed [SW-1:0]        nr_s;
  logic signed [SW-1:0]        nc_s;
  logic [RW-1:0]               nr;
  logic [RW-1:0]               nc;
  logic [PW-1:0]               prod_r;
  logic [PW-1:0]               prod_c;
  logic [knsp_pkg::DIST_W:0]   sum;

  always_comb begin
    nr_s = $signed({2'b00, row}) + SW'(knsp_pkg::MOVE_DR[move]);
    nc_s = $signed({2'b00, col}) + SW'(knsp_pkg::MOVE_DC[move]);
    on_board = (nr_s >= 0) && (nr_s < SW'(BOARD_SIDE)) &&
               (nc_s >= 0) && (nc_s < SW'(BOARD_SIDE));
    nr = nr_s[RW-1:0];
    nc = nc_s[RW-1:0];
    nidx = AW'(nr) * AW'(BOARD_SIDE) + AW'(nc);
    prod_r = PW'(row) * PW'(nr);
    prod_c = PW'(col) * PW'(nc);
    sum = (knsp_pkg::DIST_W + 1)'(base) + (knsp_pkg::DIST_W + 1)'(prod_r) +
          (knsp_pkg::DIST_W + 1)'(prod_c);
    // Clamp so that a finite cost never aliases the infinity code.
    if (sum > (knsp_pkg::DIST_W + 1)'(knsp_pkg::DIST_MAX_FINITE)) begin
      cand = knsp_pkg::DIST_MAX_FINITE;
    end else begin
      cand = sum[knsp_pkg::DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/knight_weighted_shortest_path_unit.sv */
// ----------------------------------------------------------------------------
// knight_weighted_shortest_path_unit
// The time from the start beat to done grows with the number of scan passes
//   (full passes of BOARD_SIDE^2 squares, the last one clean), with the
//   pending squares taken and with their moves; it is set by the single
//   distance memory doing one read-modify-write per on-board move.
// Throughput: one query at a time; busy stays high until the done beat.
// Reset: rst (synchronous) returns the sequencer to idle and clears the
//   pending and valid bits; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module knight_weighted_shortest_path_unit #(
  parameter int BOARD_SIDE = knsp_pkg::BOARD_SIDE_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire [knsp_pkg::COORD_IN_W-1:0]     start_row,
  input  wire [knsp_pkg::COORD_IN_W-1:0]     start_col,
  input  wire [knsp_pkg::COORD_IN_W-1:0]     target_row,
  input  wire [knsp_pkg::COORD_IN_W-1:0]     target_col,
  output logic                               done,
  output logic [knsp_pkg::DIST_W-1:0]        path_cost,
  output logic                               reached
);

  // Square count, address width and row/column width follow from the side.
  localparam int SQUARES = BOARD_SIDE * BOARD_SIDE;
  localparam int AW      = $clog2(SQUARES);
  localparam int RW      = $clog2(BOARD_SIDE);
  // Comparison width wide enough for both a query coordinate and the side.
  localparam int CMPW    = (RW > knsp_pkg::COORD_IN_W ? RW : knsp_pkg::COORD_IN_W) + 1;
  localparam logic [RW-1:0] LAST_RC = RW'(BOARD_SIDE - 1);
  localparam logic [knsp_pkg::MOVE_W-1:0] LAST_MOVE =
    knsp_pkg::MOVE_W'(knsp_pkg::MOVE_CNT - 1);

  knsp_pkg::knsp_state_t state, state_next;

  // Pending flags, one per square. The scan pointer sweeps the board in
  // passes; a pass that finds nothing pending ends the search, because a
  // square only turns pending while some other square is being processed.
  logic [SQUARES-1:0]               pending;
  logic [RW-1:0]                    scan_r;
  logic [RW-1:0]                    scan_c;
  logic [AW-1:0]                    scan_idx;
  logic                             pass_hit;
  logic                             scan_hit;
  logic                             scan_wrap;

  // The square being relaxed and the move under way.
  logic [RW-1:0]                    cur_r;
  logic [RW-1:0]                    cur_c;
  logic [knsp_pkg::DIST_W-1:0]      base;
  logic [knsp_pkg::MOVE_W-1:0]      move;
  logic [AW-1:0]                    nidx_q;
  logic [knsp_pkg::DIST_W-1:0]      cand_q;

  // Target latched at the start beat.
  logic                             tgt_ok;
  logic [AW-1:0]                    tgt_idx;

  // Query decode.
  logic                             accept;
  logic                             src_ok;
  logic                             dst_ok;
  logic [AW-1:0]                    src_idx;
  logic [AW-1:0]                    dst_idx;

  // Move calculator results.
  logic                             mv_on_board;
  logic [AW-1:0]                    mv_nidx;
  logic [knsp_pkg::DIST_W-1:0]      mv_cand;

  // Memory port.
  logic                             mem_clear;
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [knsp_pkg::DIST_W-1:0]      mem_wdata;
  logic                             mem_re;
  logic [AW-1:0]                    mem_raddr;
  logic [knsp_pkg::DIST_W-1:0]      mem_rdata;

  logic                             improve;

  assign busy   = (state != knsp_pkg::ST_IDLE);
  assign accept = start && !busy;

  // A query coordinate at or beyond the side lies off the board, which can
  // only happen when the board side is smaller than eight.
  assign src_ok  = (CMPW'(start_row) < CMPW'(BOARD_SIDE)) &&
                   (CMPW'(start_col) < CMPW'(BOARD_SIDE));
  assign dst_ok  = (CMPW'(target_row) < CMPW'(BOARD_SIDE)) &&
                   (CMPW'(target_col) < CMPW'(BOARD_SIDE));
  assign src_idx = AW'(RW'(start_row)) * AW'(BOARD_SIDE) + AW'(RW'(start_col));
  assign dst_idx = AW'(RW'(target_row)) * AW'(BOARD_SIDE) + AW'(RW'(target_col));

  assign scan_idx  = AW'(scan_r) * AW'(BOARD_SIDE) + AW'(scan_c);
  assign scan_hit  = pending[scan_idx];
  assign scan_wrap = (scan_r == LAST_RC) && (scan_c == LAST_RC);

  // The write in the compare cycle lands before any later read is issued,
  // and one square's eight neighbors are all distinct, so the
  // read-modify-write sequence needs no forwarding.
  assign improve = (cand_q < mem_rdata);

  knsp_move_calc #(
    .BOARD_SIDE (BOARD_SIDE),
    .RW         (RW),
    .AW         (AW)
  ) u_move (
    .row      (cur_r),
    .col      (cur_c),
    .move     (move),
    .base     (base),
    .on_board (mv_on_board),
    .nidx     (mv_nidx),
    .cand     (mv_cand)
  );

  knsp_dist_mem #(
    .DEPTH (SQUARES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .clear (mem_clear),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      knsp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = knsp_pkg::ST_SCAN;
        end
      end
      knsp_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_next = knsp_pkg::ST_BASE;
        end else if (scan_wrap && !pass_hit) begin
          state_next = knsp_pkg::ST_FINISH;
        end
      end
      knsp_pkg::ST_BASE: begin
        state_next = knsp_pkg::ST_MREAD;
      end
      knsp_pkg::ST_MREAD: begin
        if (mv_on_board) begin
          state_next = knsp_pkg::ST_MWRITE;
        end else if (move == LAST_MOVE) begin
          state_next = knsp_pkg::ST_SCAN;
        end
      end
      knsp_pkg::ST_MWRITE: begin
        if (move == LAST_MOVE) begin
          state_next = knsp_pkg::ST_SCAN;
        end else begin
          state_next = knsp_pkg::ST_MREAD;
        end
      end
      knsp_pkg::ST_FINISH: begin
        state_next = knsp_pkg::ST_REPORT;
      end
      knsp_pkg::ST_REPORT: begin
        state_next = knsp_pkg::ST_IDLE;
      end
      default: begin
        state_next = knsp_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory port control per state.
  always_comb begin
    mem_clear = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = src_idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = scan_idx;
    case (state)
      knsp_pkg::ST_IDLE: begin
        // The start square is written with distance zero as the board clears.
        mem_clear = start;
        mem_we    = start && src_ok;
      end
      knsp_pkg::ST_SCAN: begin
        mem_re = scan_hit;
      end
      knsp_pkg::ST_MREAD: begin
        mem_re    = mv_on_board;
        mem_raddr = mv_nidx;
      end
      knsp_pkg::ST_MWRITE: begin
        mem_we    = improve;
        mem_waddr = nidx_q;
        mem_wdata = cand_q;
      end
      knsp_pkg::ST_FINISH: begin
        mem_re    = 1'b1;
        mem_raddr = tgt_idx;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= knsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pending flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case (state)
        knsp_pkg::ST_IDLE: begin
          if (start) begin
            pending <= '0;
            if (src_ok) begin
              pending[src_idx] <= 1'b1;
            end
          end
        end
        knsp_pkg::ST_SCAN: begin
          if (scan_hit) begin
            pending[scan_idx] <= 1'b0;
          end
        end
        knsp_pkg::ST_MWRITE: begin
          if (improve) begin
            pending[nidx_q] <= 1'b1;
          end
        end
        default: begin
          pending <= pending;
        end
      endcase
    end
  end

  // Scan pointer and pass bookkeeping. The pointer moves on after a hit as
  // well; a hit before the last square marks the pass dirty to sweep again.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_r   <= '0;
      scan_c   <= '0;
      pass_hit <= 1'b0;
    end else if (accept) begin
      scan_r   <= '0;
      scan_c   <= '0;
      pass_hit <= 1'b0;
    end else if (state == knsp_pkg::ST_SCAN) begin
      if (scan_wrap) begin
        scan_r   <= '0;
        scan_c   <= '0;
        pass_hit <= 1'b0;
      end else begin
        if (scan_c == LAST_RC) begin
          scan_c <= '0;
          scan_r <= scan_r + 1'b1;
        end else begin
          scan_c <= scan_c + 1'b1;
        end
        pass_hit <= pass_hit || scan_hit;
      end
    end
  end

  // Relaxation datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_ok  <= dst_ok;
      tgt_idx <= dst_idx;
    end
    if ((state == knsp_pkg::ST_SCAN) && scan_hit) begin
      cur_r <= scan_r;
      cur_c <= scan_c;
    end
    if (state == knsp_pkg::ST_BASE) begin
      base <= mem_rdata;
      move <= '0;
    end
    if (state == knsp_pkg::ST_MREAD) begin
      nidx_q <= mv_nidx;
      cand_q <= mv_cand;
      if (!mv_on_board) begin
        move <= move + 1'b1;
      end
    end
    if (state == knsp_pkg::ST_MWRITE) begin
      move <= move + 1'b1;
    end
  end

  // Result beat, shown for exactly one cycle after the target is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == knsp_pkg::ST_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == knsp_pkg::ST_REPORT) begin
      if (tgt_ok && (mem_rdata != knsp_pkg::DIST_INF)) begin
        reached   <= 1'b1;
        path_cost <= mem_rdata;
      end else begin
        reached   <= 1'b0;
        path_cost <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/knsp_checker.sv */
// ----------------------------------------------------------------------------
// knsp_checker
// Port-level checks on the query handshake and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module knsp_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              start,
  input wire                              busy,
  input wire                              done,
  input wire [knsp_pkg::DIST_W-1:0]       path_cost,
  input wire                              reached
);

  // An accepted query makes the unit busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("query accepted but unit not busy");

  // The unit leaves busy only together with its result beat.
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  // A result beat lasts one cycle and is never shown while busy.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("result beat not a single idle cycle");

  // An unreached target reports zero cost.
  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    done && !reached |-> path_cost == '0)
    else $error("unreached target with nonzero cost");

endmodule

bind knight_weighted_shortest_path_unit knsp_checker u_knsp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .path_cost (path_cost),
  .reached   (reached)
);

`default_nettype wire

/* test/tb_knight_weighted_shortest_path_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_knight_weighted_shortest_path_unit
// Self-checking bench for the knight weighted shortest path unit. A short
// table of directed queries is followed by random queries in several sender
// idling phases. Every accepted query is answered by hand or by a behavioral
// model kept in this file, and each result beat is compared with the oldest
// answer that is still outstanding.
// ----------------------------------------------------------------------------
module tb_knight_weighted_shortest_path_unit;
  import knsp_pkg::*;

  // Board geometry follows the default of the unit under test.
  localparam int SIDE    = BOARD_SIDE_DEF;
  localparam int SQUARES = SIDE * SIDE;
  localparam int COORD_W = COORD_IN_W;

  // Distance encoding used by the model: all ones marks an unreached square,
  // and any finite sum is clamped one below that.
  localparam logic [DIST_W-1:0] COST_UNREACHED = {DIST_W{1'b1}};
  localparam int unsigned       COST_CEILING   = (1 << DIST_W) - 2;

  localparam int DIRECTED_ROWS = 16;
  localparam int PHASES        = 4;
  localparam int PER_PHASE     = 69;

  // A single query runs a whole search, so the watchdog is generous; it only
  // fires on a hang.
  localparam int STALL_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
  } knight_query_t;

  typedef struct {
    logic [DIST_W-1:0] cost;
    logic              hit;
  } path_answer_t;

  // One directed row; when typed is set the answer is written out by hand,
  // otherwise it is taken from the model.
  typedef struct {
    knight_query_t q;
    bit            typed;
    path_answer_t  ans;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [COORD_W-1:0]  start_row = '0;
  logic [COORD_W-1:0]  start_col = '0;
  logic [COORD_W-1:0]  target_row = '0;
  logic [COORD_W-1:0]  target_col = '0;
  logic                busy;
  logic                done;
  logic [DIST_W-1:0]   path_cost;
  logic                reached;

  knight_weighted_shortest_path_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .start_row  (start_row),
    .start_col  (start_col),
    .target_row (target_row),
    .target_col (target_col),
    .done       (done),
    .path_cost  (path_cost),
    .reached    (reached)
  );

  // 4 ns period: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral model of the search. Each query wipes the board, seeds the
  // start square, then repeatedly takes the lowest-numbered pending square
  // and relaxes its eight knight moves until nothing is pending.
  // --------------------------------------------------------------------------
  int                knight_dr [8] = '{-1, -2, -2, -1, 1, 2, 2, 1};
  int                knight_dc [8] = '{-2, -1, 1, 2, 2, 1, -1, -2};
  logic [DIST_W-1:0] board_cost [SQUARES];
  bit                board_open [SQUARES];

  function automatic path_answer_t solve_query(input knight_query_t q);
    path_answer_t ans;
    int           sq;
    int           r;
    int           c;
    int           nr;
    int           nc;
    int           nsq;
    int unsigned  cand;
    bit           took;
    for (int i = 0; i < SQUARES; i++) begin
      board_cost[i] = COST_UNREACHED;
      board_open[i] = 1'b0;
    end
    // A start square off the board leaves every square unreached.
    if (q.src_row < SIDE && q.src_col < SIDE) begin
      sq             = q.src_row * SIDE + q.src_col;
      board_cost[sq] = '0;
      board_open[sq] = 1'b1;
    end
    do begin
      took = 1'b0;
      for (sq = 0; sq < SQUARES && !took; sq++) begin
        if (board_open[sq]) begin
          board_open[sq] = 1'b0;
          took           = 1'b1;
          if (board_cost[sq] != COST_UNREACHED) begin
            r = sq / SIDE;
            c = sq % SIDE;
            for (int k = 0; k < 8; k++) begin
              nr = r + knight_dr[k];
              nc = c + knight_dc[k];
              if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE) begin
                // Move cost is the sum of row and column products.
                cand = board_cost[sq] + r * nr + c * nc;
                if (cand > COST_CEILING) begin
                  cand = COST_CEILING;
                end
                nsq = nr * SIDE + nc;
                if (cand < board_cost[nsq]) begin
                  board_cost[nsq] = cand[DIST_W-1:0];
                  board_open[nsq] = 1'b1;
                end
              end
            end
          end
        end
      end
    end while (took);
    // A target off the board, or one never reached, reports zero cost.
    ans.cost = '0;
    ans.hit  = 1'b0;
    if (q.dst_row < SIDE && q.dst_col < SIDE) begin
      nsq = q.dst_row * SIDE + q.dst_col;
      if (board_cost[nsq] != COST_UNREACHED) begin
        ans.cost = board_cost[nsq];
        ans.hit  = 1'b1;
      end
    end
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Answers waiting for their result beat, oldest first.
  // --------------------------------------------------------------------------
  path_answer_t awaited_answers [$];
  int           idle_pct = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  path_answer_t oldest_answer;

  // Presents one query beat. Inputs move only at the falling edge. While the
  // sender idles, start is held low; once the beat is up it stays up until a
  // rising edge sees busy low, which is the edge that takes it.
  task automatic issue_query(input knight_query_t q, input path_answer_t ans);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    start_row  <= q.src_row;
    start_col  <= q.src_col;
    target_row <= q.dst_row;
    target_col <= q.dst_col;
    do @(posedge clk); while (busy);
    awaited_answers.push_back(ans);
  endtask

  // Drops start and holds off until every outstanding answer has arrived.
  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker and watchdog. Outputs are sampled at the rising edge; the
  // result strobe cannot be held off, so every done beat is consumed here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (done) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result beat with no query outstanding (path_cost %0d, reached %0b)",
                     $time, path_cost, reached);
          end
        end else begin
          oldest_answer = awaited_answers.pop_front();
          if (path_cost !== oldest_answer.cost || reached !== oldest_answer.hit) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: path_cost expected %0d got %0d, reached expected %0b got %0b",
                       $time, oldest_answer.cost, path_cost, oldest_answer.hit, reached);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  directed_row_t directed_table [DIRECTED_ROWS];
  int            phase_idle [PHASES] = '{0, 80, 0, 33};

  initial begin
    knight_query_t q;
    path_answer_t  ans;

    // Start equals target costs nothing, and from the origin every move
    // costs zero, so those rows carry a written answer.
    directed_table = '{
      '{'{3'd0, 3'd0, 3'd0, 3'd0}, 1'b1, '{13'd0, 1'b1}},
      '{'{3'd7, 3'd7, 3'd7, 3'd7}, 1'b1, '{13'd0, 1'b1}},
      '{'{3'd0, 3'd0, 3'd1, 3'd2}, 1'b1, '{13'd0, 1'b1}},
      '{'{3'd0, 3'd0, 3'd2, 3'd1}, 1'b1, '{13'd0, 1'b1}},
      '{'{3'd7, 3'd0, 3'd7, 3'd0}, 1'b1, '{13'd0, 1'b1}},
      '{'{3'd0, 3'd0, 3'd7, 3'd7}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd7, 3'd7, 3'd0, 3'd0}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd0, 3'd7, 3'd7, 3'd0}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd7, 3'd0, 3'd0, 3'd7}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd3, 3'd3, 3'd4, 3'd4}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd0, 3'd0, 3'd0, 3'd1}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd7, 3'd7, 3'd7, 3'd6}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd5, 3'd2, 3'd2, 3'd5}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd1, 3'd1, 3'd6, 3'd6}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd4, 3'd3, 3'd0, 3'd0}, 1'b0, '{13'd0, 1'b0}},
      '{'{3'd6, 3'd6, 3'd0, 3'd7}, 1'b0, '{13'd0, 1'b0}}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, back to back.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      ans = directed_table[i].typed ? directed_table[i].ans : solve_query(directed_table[i].q);
      issue_query(directed_table[i].q, ans);
    end

    // Random part. Each phase sets how often the sender idles before a beat;
    // the third phase opens with the sender waiting for all answers, and a
    // few such pauses are scattered everywhere.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = phase_idle[p];
      if (p == 2) begin
        hold_until_drained();
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        q.src_row = COORD_W'($urandom_range(7));
        q.src_col = COORD_W'($urandom_range(7));
        q.dst_row = COORD_W'($urandom_range(7));
        q.dst_col = COORD_W'($urandom_range(7));
        // Now and then ask for the start square itself.
        if ($urandom_range(7) == 0) begin
          q.dst_row = q.src_row;
          q.dst_col = q.src_col;
        end
        if ($urandom_range(24) == 0) begin
          hold_until_drained();
        end
        issue_query(q, solve_query(q));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
